FILE: design/bhp_pkg.sv
package bhp_pkg;

    // Field widths
    localparam int RAW_ADC_W   = 16;
    localparam int ECHO_W      = 16;
    localparam int DUTY_W      = 11;
    localparam int SETPOINT_W  = 16;
    localparam int DISTANCE_W  = 19;
    localparam int ERROR_W     = 20;

    // Register widths
    localparam int GAIN_W      = 40;
    localparam int TICK_W      = 10;
    localparam int ADC_CODE_W  = 12;
    localparam int CM_W        = 8;
    localparam int TIMEOUT_W   = 16;

    // Configuration port
    localparam int APB_ADDR_W  = 6;
    localparam int APB_DATA_W  = 64;
    localparam int REG_IDX_W   = 3;

    localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_INTEG   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIV   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TICK_MS      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ADC_FS       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SP_MIN       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SP_MAX       = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ECHO_TIMEOUT = 3'd7;

    // Register reset values
    localparam logic [GAIN_W-1:0]     GAIN_PROP_RST  = 40'd214748365;
    localparam logic [GAIN_W-1:0]     GAIN_INTEG_RST = 40'd16777;
    localparam logic [GAIN_W-1:0]     GAIN_DERIV_RST = 40'd92274688000;
    localparam logic [TICK_W-1:0]     TICK_MS_RST    = 10'd23;
    localparam logic [ADC_CODE_W-1:0] ADC_FS_RST     = 12'd1735;
    localparam logic [CM_W-1:0]       SP_MIN_RST     = 8'd10;
    localparam logic [CM_W-1:0]       SP_MAX_RST     = 8'd90;
    localparam logic [TIMEOUT_W-1:0]  ECHO_TO_RST    = 16'd18500;

    // Shared serial multiplier: a is taken whole, b one bit a step
    localparam int MUL_A_W   = 48;
    localparam int MUL_B_W   = 40;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // Shared serial divider: one quotient bit a step
    localparam int DIV_N_W   = 60;
    localparam int DIV_D_W   = 12;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    // Arithmetic constants
    localparam logic [DIV_D_W-1:0]   DIST_DIVISOR = 12'd1000;
    localparam logic signed [48:0]   INTEG_LIM    = 49'sd140737488355327;
    localparam logic [63:0]          ITERM_LIM    = 64'h2000_0000_0000_0000;
    localparam logic [31:0]          DUTY_MAX_HI  = 32'd1024;
    localparam logic [DUTY_W-1:0]    DUTY_MAX     = 11'd1024;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SP_MUL,
        ST_SP_DIV,
        ST_DIST_DIV,
        ST_ERR,
        ST_ET_MUL,
        ST_P_MUL,
        ST_I_MUL,
        ST_D_MUL,
        ST_D_DIV,
        ST_FINISH
    } bhp_state_t;

endpackage

FILE: design/bhp_ifs.sv
// Input word channel
interface bhp_in_if import bhp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [RAW_ADC_W-1:0] raw_adc_word;
    logic [ECHO_W-1:0]    echo_width_us;

    modport source (output valid, output raw_adc_word, output echo_width_us, input ready);
    modport sink   (input valid, input raw_adc_word, input echo_width_us, output ready);
endinterface

// Result word channel
interface bhp_out_if import bhp_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [DUTY_W-1:0]           drive_duty;
    logic [SETPOINT_W-1:0]       setpoint_q8;
    logic [DISTANCE_W-1:0]       distance_q8;
    logic signed [ERROR_W-1:0]   error_q8;
    logic                        drive_clamped;

    modport source (output valid, output drive_duty, output setpoint_q8, output distance_q8,
                    output error_q8, output drive_clamped, input ready);
    modport sink   (input valid, input drive_duty, input setpoint_q8, input distance_q8,
                    input error_q8, input drive_clamped, output ready);
endinterface

FILE: design/bhp_mul.sv
module bhp_mul import bhp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  mul_req_t           req,
    output logic               done,
    output logic [MUL_P_W-1:0] product
);

    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_A_W-1:0]   hi_reg;
    logic [MUL_B_W-1:0]   lo_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_A_W:0]     sum;
    logic                 last;

    // One partial product per step, low product bits shift into lo_reg
    assign sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
    assign last = (cnt_reg == MUL_CNT_W'(MUL_B_W - 1));

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + MUL_CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Shift-add datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg  <= req.a;
            hi_reg <= '0;
            lo_reg <= req.b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[MUL_A_W:1];
            lo_reg <= {sum[0], lo_reg[MUL_B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

FILE: design/bhp_div.sv
module bhp_div import bhp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  div_req_t           req,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    logic [DIV_N_W-1:0]   n_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_D_W+1:0]   trial;
    logic                 ge;
    logic                 last;

    // Restoring step: bring down one dividend bit, try the subtract
    assign trial = {1'b0, rem_reg, n_reg[DIV_N_W-1]} - {2'b0, dvs_reg};
    assign ge    = ~trial[DIV_D_W+1];
    assign last  = (cnt_reg == DIV_CNT_W'(DIV_N_W - 1));

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Dividend shifts out the top, quotient bits shift in the bottom
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            n_reg   <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[DIV_N_W-2:0], ge};
            rem_reg <= ge ? trial[DIV_D_W-1:0] : {rem_reg[DIV_D_W-2:0], n_reg[DIV_N_W-1]};
        end
    end

    assign done     = done_reg;
    assign quotient = n_reg;

endmodule

FILE: design/ball_height_pid_controller.sv
// Channel   Dir  Fields                                             Handshake
// sample    in   raw_adc_word[16], echo_width_us[16]                valid/ready
// result    out  drive_duty[11], setpoint_q8[16], distance_q8[19],  valid/ready
//                error_q8[20] signed, drive_clamped[1]
// apb       in   64-bit registers at byte address 8*index           pready tied high
//
// Words are taken only in idle, so a word is done before the next is accepted;
// each makes five passes through the shared 40-step shift-add multiplier and
// three through the 60-step restoring divider, plus an error and a finish step.
// Reset clears the registers to their defaults and the previous error and integral to 0.
// A new word is accepted while a finished result waits; a stalled result holds the
// sequencer in its last step until the result register frees.
module ball_height_pid_controller import bhp_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    bhp_in_if.sink                sample,
    bhp_out_if.source             result
);

    // Configuration registers
    logic [GAIN_W-1:0]     gain_prop_reg;
    logic [GAIN_W-1:0]     gain_integ_reg;
    logic [GAIN_W-1:0]     gain_deriv_reg;
    logic [TICK_W-1:0]     tick_ms_reg;
    logic [ADC_CODE_W-1:0] adc_fs_reg;
    logic [CM_W-1:0]       sp_min_reg;
    logic [CM_W-1:0]       sp_max_reg;
    logic [TIMEOUT_W-1:0]  echo_to_reg;
    logic [REG_IDX_W-1:0]  cfg_idx;
    logic                  cfg_wr;

    // Sequencer
    bhp_state_t state_reg;
    bhp_state_t state_next;
    logic       go_reg;
    logic       in_fire;
    logic       out_load;

    // Datapath
    logic [ADC_CODE_W-1:0] code_reg;
    logic [28:0]           echo_num_reg;
    logic [SETPOINT_W-1:0] sp_reg;
    logic [DISTANCE_W-1:0] dist_reg;
    logic [ERROR_W-1:0]    err_reg;
    logic [ERROR_W:0]      derr_reg;
    logic [ERROR_W-1:0]    prev_err_reg;
    logic [47:0]           integ_reg;
    logic [63:0]           acc_reg;

    // Result register
    logic                  out_valid_reg;
    logic [DUTY_W-1:0]     duty_reg;
    logic [SETPOINT_W-1:0] sp_out_reg;
    logic [DISTANCE_W-1:0] dist_out_reg;
    logic [ERROR_W-1:0]    err_out_reg;
    logic                  clamp_out_reg;

    // Shared units
    mul_req_t           mul_req;
    logic               mul_done;
    logic [MUL_P_W-1:0] mul_prod;
    div_req_t           div_req;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quot;

    // Combinational helpers
    logic [TICK_W-1:0]     tick_eff;
    logic [ADC_CODE_W-1:0] fs_eff;
    logic [15:0]           raw_swapped;
    logic [ECHO_W-1:0]     echo_clip;
    logic                  sp_neg;
    logic [CM_W-1:0]       diff_mag;
    logic [ERROR_W-1:0]    err_abs;
    logic [ERROR_W:0]      derr_abs;
    logic [47:0]           integ_abs;
    logic signed [29:0]    sp_sum;
    logic [SETPOINT_W-1:0] sp_sat;
    logic [ERROR_W-1:0]    err_new;
    logic [ERROR_W:0]      derr_new;
    logic [48:0]           et_term;
    logic signed [48:0]    integ_sum;
    logic [47:0]           integ_sat;
    logic                  iterm_big;
    logic [63:0]           term_mag;
    logic                  term_neg;
    logic [63:0]           acc_base;
    logic [63:0]           acc_sum;
    logic                  acc_upd;
    logic                  over_hi;
    logic [DUTY_W-1:0]     duty_calc;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg  <= GAIN_PROP_RST;
            gain_integ_reg <= GAIN_INTEG_RST;
            gain_deriv_reg <= GAIN_DERIV_RST;
            tick_ms_reg    <= TICK_MS_RST;
            adc_fs_reg     <= ADC_FS_RST;
            sp_min_reg     <= SP_MIN_RST;
            sp_max_reg     <= SP_MAX_RST;
            echo_to_reg    <= ECHO_TO_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GAIN_PROP:    gain_prop_reg  <= pwdata[GAIN_W-1:0];
                REG_GAIN_INTEG:   gain_integ_reg <= pwdata[GAIN_W-1:0];
                REG_GAIN_DERIV:   gain_deriv_reg <= pwdata[GAIN_W-1:0];
                REG_TICK_MS:      tick_ms_reg    <= pwdata[TICK_W-1:0];
                REG_ADC_FS:       adc_fs_reg     <= pwdata[ADC_CODE_W-1:0];
                REG_SP_MIN:       sp_min_reg     <= pwdata[CM_W-1:0];
                REG_SP_MAX:       sp_max_reg     <= pwdata[CM_W-1:0];
                REG_ECHO_TIMEOUT: echo_to_reg    <= pwdata[TIMEOUT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (cfg_idx)
            REG_GAIN_PROP:    prdata = APB_DATA_W'(gain_prop_reg);
            REG_GAIN_INTEG:   prdata = APB_DATA_W'(gain_integ_reg);
            REG_GAIN_DERIV:   prdata = APB_DATA_W'(gain_deriv_reg);
            REG_TICK_MS:      prdata = APB_DATA_W'(tick_ms_reg);
            REG_ADC_FS:       prdata = APB_DATA_W'(adc_fs_reg);
            REG_SP_MIN:       prdata = APB_DATA_W'(sp_min_reg);
            REG_SP_MAX:       prdata = APB_DATA_W'(sp_max_reg);
            REG_ECHO_TIMEOUT: prdata = APB_DATA_W'(echo_to_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input conditioning
    // ------------------------------------------------------------------
    // A zero interval or full scale counts as one
    assign tick_eff    = (tick_ms_reg == '0) ? TICK_W'(1) : tick_ms_reg;
    assign fs_eff      = (adc_fs_reg == '0) ? ADC_CODE_W'(1) : adc_fs_reg;
    assign raw_swapped = {sample.raw_adc_word[7:0], sample.raw_adc_word[15:8]};
    assign echo_clip   = (sample.echo_width_us > echo_to_reg) ? echo_to_reg
                                                              : sample.echo_width_us;

    // Setpoint slope sign and magnitude
    assign sp_neg   = (sp_max_reg < sp_min_reg);
    assign diff_mag = sp_neg ? (sp_min_reg - sp_max_reg) : (sp_max_reg - sp_min_reg);

    // Operand magnitudes
    assign err_abs   = err_reg[ERROR_W-1] ? (~err_reg + ERROR_W'(1)) : err_reg;
    assign derr_abs  = derr_reg[ERROR_W] ? (~derr_reg + (ERROR_W+1)'(1)) : derr_reg;
    assign integ_abs = integ_reg[47] ? (~integ_reg + 48'd1) : integ_reg;

    // ------------------------------------------------------------------
    // Step results
    // ------------------------------------------------------------------
    // Setpoint: min*256 plus signed quotient, saturated to 16 bits
    assign sp_sum = $signed({14'b0, sp_min_reg, 8'b0})
                  + (sp_neg ? -$signed({2'b0, div_quot[27:0]}) : $signed({2'b0, div_quot[27:0]}));
    assign sp_sat = sp_sum[29] ? '0 : ((|sp_sum[28:16]) ? 16'hFFFF : sp_sum[15:0]);

    // Error and its change since the last word
    assign err_new  = {4'b0, sp_reg} - {1'b0, dist_reg};
    assign derr_new = {err_new[ERROR_W-1], err_new} - {prev_err_reg[ERROR_W-1], prev_err_reg};

    // Integral update with saturation
    assign et_term   = err_reg[ERROR_W-1] ? (~{20'b0, mul_prod[28:0]} + 49'd1)
                                          : {20'b0, mul_prod[28:0]};
    assign integ_sum = $signed({integ_reg[47], integ_reg}) + $signed(et_term);

    always_comb
    begin
        if (integ_sum > INTEG_LIM)
        begin
            integ_sat = INTEG_LIM[47:0];
        end
        else if (integ_sum < -INTEG_LIM)
        begin
            integ_sat = 48'(-INTEG_LIM);
        end
        else
        begin
            integ_sat = integ_sum[47:0];
        end
    end

    // I term magnitude caps at 2^61
    assign iterm_big = (|mul_prod[MUL_P_W-1:62]) || (mul_prod[61] && (|mul_prod[60:0]));

    // PID sum accumulator: one signed term per step
    always_comb
    begin
        term_mag = '0;
        term_neg = 1'b0;
        acc_base = acc_reg;
        case (state_reg)
            ST_P_MUL:
            begin
                term_mag = {5'b0, mul_prod[58:0]};
                term_neg = err_reg[ERROR_W-1];
                acc_base = '0;
            end
            ST_I_MUL:
            begin
                term_mag = iterm_big ? ITERM_LIM : {2'b0, mul_prod[61:0]};
                term_neg = integ_reg[47];
            end
            ST_D_DIV:
            begin
                term_mag = {4'b0, div_quot};
                term_neg = derr_reg[ERROR_W];
            end
            default: ;
        endcase
    end

    assign acc_sum = acc_base + (term_neg ? (~term_mag + 64'd1) : term_mag);
    assign acc_upd = (((state_reg == ST_P_MUL) || (state_reg == ST_I_MUL)) && mul_done)
                   || ((state_reg == ST_D_DIV) && div_done);

    // Drive clamp
    assign over_hi   = (acc_reg[63:32] > DUTY_MAX_HI)
                     || ((acc_reg[63:32] == DUTY_MAX_HI) && (|acc_reg[31:0]));
    assign duty_calc = acc_reg[63] ? '0 : (over_hi ? DUTY_MAX : acc_reg[42:32]);

    // ------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_req.start = go_reg && (state_reg inside {ST_SP_MUL, ST_ET_MUL, ST_P_MUL,
                                                     ST_I_MUL, ST_D_MUL});
        mul_req.a     = '0;
        mul_req.b     = '0;
        case (state_reg)
            ST_SP_MUL:
            begin
                mul_req.a = MUL_A_W'(code_reg);
                mul_req.b = MUL_B_W'(diff_mag);
            end
            ST_ET_MUL:
            begin
                mul_req.a = MUL_A_W'(err_abs);
                mul_req.b = MUL_B_W'(tick_eff);
            end
            ST_P_MUL:
            begin
                mul_req.a = MUL_A_W'(err_abs);
                mul_req.b = gain_prop_reg;
            end
            ST_I_MUL:
            begin
                mul_req.a = integ_abs;
                mul_req.b = gain_integ_reg;
            end
            ST_D_MUL:
            begin
                mul_req.a = MUL_A_W'(derr_abs);
                mul_req.b = gain_deriv_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        div_req.start    = go_reg && (state_reg inside {ST_SP_DIV, ST_DIST_DIV, ST_D_DIV});
        div_req.dividend = '0;
        div_req.divisor  = DIV_D_W'(1);
        case (state_reg)
            ST_SP_DIV:
            begin
                div_req.dividend = DIV_N_W'({mul_prod[19:0], 8'b0});
                div_req.divisor  = fs_eff;
            end
            ST_DIST_DIV:
            begin
                div_req.dividend = DIV_N_W'(echo_num_reg);
                div_req.divisor  = DIST_DIVISOR;
            end
            ST_D_DIV:
            begin
                div_req.dividend = mul_prod[DIV_N_W-1:0];
                div_req.divisor  = DIV_D_W'(tick_eff);
            end
            default: ;
        endcase
    end

    bhp_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    bhp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= (state_next != state_reg);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        sample.ready = (state_reg == ST_IDLE);
        in_fire      = sample.valid && (state_reg == ST_IDLE);
        out_load     = (state_reg == ST_FINISH) && (!out_valid_reg || result.ready);
        case (state_reg)
            ST_IDLE:     if (in_fire)  state_next = ST_SP_MUL;
            ST_SP_MUL:   if (mul_done) state_next = ST_SP_DIV;
            ST_SP_DIV:   if (div_done) state_next = ST_DIST_DIV;
            ST_DIST_DIV: if (div_done) state_next = ST_ERR;
            ST_ERR:                    state_next = ST_ET_MUL;
            ST_ET_MUL:   if (mul_done) state_next = ST_P_MUL;
            ST_P_MUL:    if (mul_done) state_next = ST_I_MUL;
            ST_I_MUL:    if (mul_done) state_next = ST_D_MUL;
            ST_D_MUL:    if (mul_done) state_next = ST_D_DIV;
            ST_D_DIV:    if (div_done) state_next = ST_FINISH;
            ST_FINISH:   if (out_load) state_next = ST_IDLE;
            default:                   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller state: previous error and integral
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            integ_reg    <= '0;
        end
        else
        begin
            if ((state_reg == ST_ET_MUL) && mul_done)
            begin
                integ_reg <= integ_sat;
            end
            if (out_load)
            begin
                prev_err_reg <= err_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Working registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            code_reg     <= raw_swapped[15:4];
            echo_num_reg <= {1'b0, echo_clip, 12'b0} + {5'b0, echo_clip, 8'b0};
        end
        if ((state_reg == ST_SP_DIV) && div_done)
        begin
            sp_reg <= sp_sat;
        end
        if ((state_reg == ST_DIST_DIV) && div_done)
        begin
            dist_reg <= div_quot[DISTANCE_W-1:0];
        end
        if (state_reg == ST_ERR)
        begin
            err_reg  <= err_new;
            derr_reg <= derr_new;
        end
        if (acc_upd)
        begin
            acc_reg <= acc_sum;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            duty_reg      <= duty_calc;
            sp_out_reg    <= sp_reg;
            dist_out_reg  <= dist_reg;
            err_out_reg   <= err_reg;
            clamp_out_reg <= acc_reg[63] || over_hi;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.drive_duty    = duty_reg;
    assign result.setpoint_q8   = sp_out_reg;
    assign result.distance_q8   = dist_out_reg;
    assign result.error_q8      = $signed(err_out_reg);
    assign result.drive_clamped = clamp_out_reg;

endmodule

FILE: sim/tb_ball_height_pid_controller.sv
`timescale 1ns / 1ps

module tb_ball_height_pid_controller import bhp_pkg::*; ();

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 8;
    localparam int LATENCY = 400;
    localparam int GAP_MAX = 450;
    localparam int STALL_MAX = 400;
    localparam int HOLD_CYCLES = 3000;
    localparam int RANDOM_PHASES = 10;
    localparam int WORDS_PER_PHASE = 123;
    localparam int CYCLE_LIMIT = 4 * (1300 * (LATENCY + GAP_MAX + STALL_MAX) + HOLD_CYCLES);

    localparam longint INTEG_MAX = 64'sd140737488355327;
    localparam longint unsigned ITERM_MAX = 64'h2000_0000_0000_0000;
    localparam longint DUTY_CEIL = 64'sd4398046511104;  // 1024 in Q32

    typedef struct packed {
        logic [DUTY_W-1:0]     duty;
        logic [SETPOINT_W-1:0] setpoint;
        logic [DISTANCE_W-1:0] distance;
        logic [ERROR_W-1:0]    err_q8;
        logic                  clamped;
    } pid_result_t;

    // Tracks register settings and controller state, predicts each result word
    class pid_scoreboard;
        logic [GAIN_W-1:0]     gain_prop;
        logic [GAIN_W-1:0]     gain_integ;
        logic [GAIN_W-1:0]     gain_deriv;
        logic [TICK_W-1:0]     tick_ms;
        logic [ADC_CODE_W-1:0] adc_fs;
        logic [CM_W-1:0]       sp_min;
        logic [CM_W-1:0]       sp_max;
        logic [TIMEOUT_W-1:0]  echo_timeout;
        longint                last_err;
        longint                integ_acc;
        pid_result_t           expected_results[$];
        int                    errors;
        int                    checked;

        function new();
            gain_prop = GAIN_PROP_RST;
            gain_integ = GAIN_INTEG_RST;
            gain_deriv = GAIN_DERIV_RST;
            tick_ms = TICK_MS_RST;
            adc_fs = ADC_FS_RST;
            sp_min = SP_MIN_RST;
            sp_max = SP_MAX_RST;
            echo_timeout = ECHO_TO_RST;
            last_err = 0;
            integ_acc = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
            case (idx)
                REG_GAIN_PROP:    gain_prop = value[GAIN_W-1:0];
                REG_GAIN_INTEG:   gain_integ = value[GAIN_W-1:0];
                REG_GAIN_DERIV:   gain_deriv = value[GAIN_W-1:0];
                REG_TICK_MS:      tick_ms = value[TICK_W-1:0];
                REG_ADC_FS:       adc_fs = value[ADC_CODE_W-1:0];
                REG_SP_MIN:       sp_min = value[CM_W-1:0];
                REG_SP_MAX:       sp_max = value[CM_W-1:0];
                REG_ECHO_TIMEOUT: echo_timeout = value[TIMEOUT_W-1:0];
                default: ;
            endcase
        endfunction

        // One control tick: setpoint, distance, error, then the PID sum
        function pid_result_t predict_tick(input logic [RAW_ADC_W-1:0] raw,
                                           input logic [ECHO_W-1:0] echo);
            pid_result_t res;
            logic [15:0] swapped;
            longint code, fs, tick, setpoint, distance, err;
            longint p_term, i_term, d_term, pid_sum;
            longint unsigned echo_clip, mag, i_mag;

            swapped = {raw[7:0], raw[15:8]};
            code = longint'(swapped[15:4]);
            // zero full scale and zero tick act as 1
            fs = (adc_fs == 0) ? 64'sd1 : longint'(adc_fs);
            tick = (tick_ms == 0) ? 64'sd1 : longint'(tick_ms);

            // linear map, extrapolated past full scale, then saturated
            setpoint = longint'(sp_min) * 256
                     + ((longint'(sp_max) - longint'(sp_min)) * code * 256) / fs;
            if (setpoint < 0)
                setpoint = 0;
            if (setpoint > 65535)
                setpoint = 65535;

            echo_clip = 64'((echo > echo_timeout) ? echo_timeout : echo);
            distance = longint'(echo_clip * 4352 / 1000);
            err = setpoint - distance;

            // integral accumulates and saturates
            integ_acc = integ_acc + err * tick;
            if (integ_acc > INTEG_MAX)
                integ_acc = INTEG_MAX;
            if (integ_acc < -INTEG_MAX)
                integ_acc = -INTEG_MAX;

            p_term = longint'(gain_prop) * err;
            if (integ_acc < 0)
                mag = -integ_acc;
            else
                mag = integ_acc;
            if (gain_integ != 0 && mag > ITERM_MAX / gain_integ)
                i_mag = ITERM_MAX;
            else
                i_mag = gain_integ * mag;
            i_term = (integ_acc < 0) ? -longint'(i_mag) : longint'(i_mag);
            d_term = (longint'(gain_deriv) * (err - last_err)) / tick;
            pid_sum = p_term + i_term + d_term;
            last_err = err;

            if (pid_sum < 0)
            begin
                res.duty = '0;
                res.clamped = 1'b1;
            end
            else if (pid_sum > DUTY_CEIL)
            begin
                res.duty = DUTY_MAX;
                res.clamped = 1'b1;
            end
            else
            begin
                res.duty = pid_sum[42:32];
                res.clamped = 1'b0;
            end
            res.setpoint = setpoint[SETPOINT_W-1:0];
            res.distance = distance[DISTANCE_W-1:0];
            res.err_q8 = err[ERROR_W-1:0];
            return res;
        endfunction

        function void note_sample(input logic [RAW_ADC_W-1:0] raw, input logic [ECHO_W-1:0] echo);
            expected_results.push_back(predict_tick(raw, echo));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(input string msg);
            errors++;
            $display("ERROR: %s", msg);
        endtask

        task check_result(input pid_result_t got);
            pid_result_t exp_word;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result word %0d arrived with nothing outstanding", checked));
            end
            else
            begin
                exp_word = expected_results.pop_front();
                if (got.duty !== exp_word.duty)
                    report($sformatf("word %0d drive_duty %0d, want %0d",
                                     checked, got.duty, exp_word.duty));
                if (got.setpoint !== exp_word.setpoint)
                    report($sformatf("word %0d setpoint_q8 %0d, want %0d",
                                     checked, got.setpoint, exp_word.setpoint));
                if (got.distance !== exp_word.distance)
                    report($sformatf("word %0d distance_q8 %0d, want %0d",
                                     checked, got.distance, exp_word.distance));
                if (got.err_q8 !== exp_word.err_q8)
                    report($sformatf("word %0d error_q8 %0d, want %0d", checked,
                                     $signed(got.err_q8), $signed(exp_word.err_q8)));
                if (got.clamped !== exp_word.clamped)
                    report($sformatf("word %0d drive_clamped %0b, want %0b",
                                     checked, got.clamped, exp_word.clamped));
            end
            checked++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    bhp_in_if sample_if ();
    bhp_out_if result_if ();

    pid_scoreboard sb;
    int unsigned cycle_count = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int burst_left = 0;
    int last_echo = 2000;
    int last_code = 0;

    ball_height_pid_controller i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_if),
        .result  (result_if)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Register write: setup cycle, access cycle, then back to idle
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                               input logic [GAIN_W-1:0] gd, input logic [TICK_W-1:0] tk,
                               input logic [ADC_CODE_W-1:0] fs, input logic [CM_W-1:0] mn,
                               input logic [CM_W-1:0] mx, input logic [TIMEOUT_W-1:0] to);
        apb_write(REG_GAIN_PROP, 64'(gp));
        apb_write(REG_GAIN_INTEG, 64'(gi));
        apb_write(REG_GAIN_DERIV, 64'(gd));
        apb_write(REG_TICK_MS, 64'(tk));
        apb_write(REG_ADC_FS, 64'(fs));
        apb_write(REG_SP_MIN, 64'(mn));
        apb_write(REG_SP_MAX, 64'(mx));
        apb_write(REG_ECHO_TIMEOUT, 64'(to));
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain(input logic [GAIN_W-1:0] nominal);
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return r[GAIN_W-1:0];
            default: return nominal >> $urandom_range(0, 6);
        endcase
    endfunction

    // Random settings with the extremes mixed in
    task automatic random_config();
        logic [TICK_W-1:0] tk;
        logic [ADC_CODE_W-1:0] fs;
        logic [CM_W-1:0] mn, mx;
        logic [TIMEOUT_W-1:0] to;
        case ($urandom_range(0, 5))
            0: tk = '0;
            1: tk = 10'd1;
            2: tk = 10'd1000;
            3: tk = '1;
            default: tk = 10'($urandom_range(1, 100));
        endcase
        case ($urandom_range(0, 5))
            0: fs = '0;
            1: fs = 12'd1;
            2: fs = '1;
            default: fs = 12'($urandom_range(1000, 4095));
        endcase
        case ($urandom_range(0, 3))
            0:
            begin
                mn = '0;
                mx = '1;
            end
            1:
            begin
                mn = 8'($urandom);
                mx = 8'($urandom);
            end
            default:
            begin
                mn = 8'($urandom_range(0, 40));
                mx = 8'($urandom_range(60, 255));
            end
        endcase
        case ($urandom_range(0, 5))
            0: to = '0;
            1: to = 16'd1;
            2: to = '1;
            default: to = 16'($urandom_range(1000, 30000));
        endcase
        load_config(pick_gain(GAIN_PROP_RST), pick_gain(GAIN_INTEG_RST),
                    pick_gain(GAIN_DERIV_RST), tk, fs, mn, mx, to);
    endtask

    // Offer one word and hold it until accepted
    task automatic send_word(input logic [RAW_ADC_W-1:0] raw, input logic [ECHO_W-1:0] echo);
        sample_if.valid <= 1'b1;
        sample_if.raw_adc_word <= raw;
        sample_if.echo_width_us <= echo;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
        sb.note_sample(raw, echo);
    endtask

    // Bursts with gaps between them; no gaps while the receiver holds off
    task automatic send_paced(input logic [RAW_ADC_W-1:0] raw, input logic [ECHO_W-1:0] echo);
        if (burst_left <= 0 && !(hold_req && !hold_done))
        begin
            sample_if.valid <= 1'b0;
            if ($urandom_range(0, 15) == 0)
                repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        send_word(raw, echo);
    endtask

    // Slow walks near the last word, some fully random, some at the edges
    task automatic next_word(output logic [RAW_ADC_W-1:0] raw, output logic [ECHO_W-1:0] echo);
        int e, c;
        logic [15:0] swapped;
        e = last_echo;
        c = last_code;
        case ($urandom_range(0, 7))
            0, 1:
            begin
                c = $urandom_range(0, 4095);
                e = $urandom_range(0, 65535);
            end
            2: e = sb.echo_timeout + $urandom_range(0, 4) - 2;
            3: c = sb.adc_fs + $urandom_range(0, 4) - 2;
            7:
            begin
                e = $urandom_range(500, 6000);
                c = $urandom_range(0, sb.adc_fs);
            end
            default:
            begin
                e = e + $urandom_range(0, 80) - 40;
                c = c + $urandom_range(0, 4) - 2;
            end
        endcase
        if (e < 0) e = 0;
        if (e > 65535) e = 65535;
        if (c < 0) c = 0;
        if (c > 4095) c = 4095;
        swapped = {c[11:0], 4'($urandom)};
        raw = {swapped[7:0], swapped[15:8]};
        echo = e[15:0];
        last_echo = e;
        last_code = c;
    endtask

    // Drop valid and let every outstanding word come back
    task automatic wait_idle();
        sample_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Receiver: changes stall pattern every so often, long hold-off on request
    initial
    begin
        int mode, mode_left, stall_left, phase_cnt;
        mode = 0;
        mode_left = 0;
        stall_left = 0;
        phase_cnt = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (mode_left <= 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 2000);
                end
                mode_left--;
                phase_cnt++;
                case (mode)
                    0: result_if.ready <= 1'b1;
                    1: result_if.ready <= 1'($urandom_range(0, 1));
                    2: result_if.ready <= (phase_cnt % 7) >= 3;
                    default:
                    begin
                        if (stall_left > 0)
                        begin
                            result_if.ready <= 1'b0;
                            stall_left--;
                        end
                        else
                        begin
                            result_if.ready <= 1'b1;
                            if ($urandom_range(0, 15) == 0)
                                stall_left = $urandom_range(1, STALL_MAX);
                        end
                    end
                endcase
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        pid_result_t got;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got.duty = result_if.drive_duty;
            got.setpoint = result_if.setpoint_q8;
            got.distance = result_if.distance_q8;
            got.err_q8 = result_if.error_q8;
            got.clamped = result_if.drive_clamped;
            sb.check_result(got);
        end
    end

    // Watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [RAW_ADC_W-1:0] raw;
        logic [ECHO_W-1:0] echo;

        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_if.valid = 1'b0;
        sample_if.raw_adc_word = '0;
        sample_if.echo_width_us = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: field extremes, code at and past full scale,
        // echo around the timeout, nibble dropped by the shift
        send_word(16'h0000, 16'd0);
        send_word(16'hFFFF, 16'hFFFF);
        send_word(16'h706C, 16'd18500);
        send_word(16'h706C, 16'd18501);
        send_word(16'h706C, 16'd18499);
        send_word(16'h0100, 16'd1);
        send_word(16'h1000, 16'd600);
        send_word(16'hF0FF, 16'd3000);
        repeat (3) send_word(16'h706C, 16'd9000);
        wait_idle();

        // Largest gains and widest span
        load_config('1, '1, '1, 10'd1000, '1, 8'd0, 8'd255, '1);
        send_word(16'h0000, 16'd0);
        send_word(16'hFFFF, 16'hFFFF);
        send_word(16'hF0FF, 16'd65535);
        send_word(16'h0F00, 16'd0);
        send_word(16'h0000, 16'd1);
        wait_idle();

        // Zero tick, zero full scale, max below min, zero timeout
        load_config(40'd0, '1, '1, 10'd0, 12'd0, 8'd255, 8'd0, 16'd0);
        send_word(16'h0000, 16'd0);
        send_word(16'h0010, 16'd5);
        send_word(16'hFFFF, 16'hFFFF);
        send_word(16'h1000, 16'd1234);
        wait_idle();

        // Full scale of one: codes above it saturate high
        load_config(GAIN_PROP_RST, GAIN_INTEG_RST, GAIN_DERIV_RST, 10'd1, 12'd1,
                    8'd0, 8'd255, ECHO_TO_RST);
        send_word(16'h1000, 16'd100);
        send_word(16'h2000, 16'd100);
        send_word(16'h0000, 16'd100);
        wait_idle();

        // Random phases; the first one starts with a long receiver hold-off
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                load_config(GAIN_PROP_RST, GAIN_INTEG_RST, GAIN_DERIV_RST, TICK_MS_RST,
                            ADC_FS_RST, SP_MIN_RST, SP_MAX_RST, ECHO_TO_RST);
                hold_req = 1'b1;
            end
            else
            begin
                random_config();
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                next_word(raw, echo);
                send_paced(raw, echo);
            end
            wait_idle();
        end

        // Let any stray result show up before the verdict
        repeat (LATENCY) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
design/bhp_pkg.sv
design/bhp_ifs.sv
design/bhp_mul.sv
design/bhp_div.sv
design/ball_height_pid_controller.sv
sim/tb_ball_height_pid_controller.sv
